// ===== src/amcw_pkg.sv =====
package amcw_pkg;

  // Input item kinds
  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DUTY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CAP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT   = 3'd4;

  // Register reset values
  localparam logic [9:0]  BASE_DUTY_RST   = 10'd150;
  localparam logic [9:0]  YAW_MAX_RST     = 10'd100;
  localparam logic [9:0]  DUTY_CAP_RST    = 10'd300;
  localparam logic [15:0] CMD_TIMEOUT_RST = 16'd3000;
  localparam logic [15:0] RUN_LIMIT_RST   = 16'd15000;

  // Largest accepted command value (10.0 in Q4.4)
  localparam logic [7:0] VALUE_MAX = 8'd160;

  // Duty in thousandths to PWM code: floor(255 * d / 1000) by reciprocal
  localparam logic [18:0] RECIP_1000 = 19'd268436;
  localparam int          RECIP_SHIFT = 28;
  localparam logic signed [11:0] DUTY_FULL = 12'sd1000;

  // LED colours
  localparam logic [23:0] LED_STRONG_LEFT  = 24'hFF00FF;
  localparam logic [23:0] LED_SOFT_LEFT    = 24'h0000FF;
  localparam logic [23:0] LED_STRAIGHT     = 24'h00FF00;
  localparam logic [23:0] LED_SOFT_RIGHT   = 24'hFFFF00;
  localparam logic [23:0] LED_STRONG_RIGHT = 24'hFF0000;
  localparam logic [23:0] LED_CUTOFF       = 24'hFF6600;
  localparam logic [23:0] LED_STALE        = 24'h331100;
  localparam logic [23:0] LED_IDLE         = 24'h111111;

  typedef struct packed {
    logic       op;
    logic [7:0] command_value;
    logic       arm_request;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  duty_front_left;
    logic [7:0]  duty_front_right;
    logic [7:0]  duty_rear_left;
    logic [7:0]  duty_rear_right;
    logic [23:0] led_color;
    logic        is_running;
    logic        is_cut_off;
  } out_item_t;

endpackage

// ===== src/armed_motor_command_watchdog.sv =====
// Armed motor command watchdog.
// Input channel (in_valid/in_ready/in_data) carries two kinds of item: a
// command (op = OP_COMMAND) with a Q4.4 value and an arm flag, and a
// one-millisecond tick (op = OP_TICK). Commands above 10.0 are dropped; a
// valid command is stored and restarts the freshness timer. Commands give
// no result. Every tick gives exactly one result item on out_valid/
// out_ready/out_data: four motor PWM codes, the LED colour, and the
// running and cut-off flags.
// An item is registered in the input stage on acceptance and evaluated
// from there by one pass of logic that writes the result register, so a
// tick's result is presented from that register once the tick leaves the
// stage. One item per cycle is taken sustained; only the result register
// limits this, and it holds a waiting result while the stage in front of
// it keeps a single item.
// When the receiver stalls, a tick waits in the input stage and in_ready
// falls; commands still drain past a full result register.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always taken and
// are meant for an idle block. Reset restores the register defaults and
// clears the stored command, counters and run state.
module armed_motor_command_watchdog
  import amcw_pkg::*;
#(
  parameter int TIME_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = TIME_BITS + 1;

  // Configuration registers
  logic [9:0]           base_duty_r;
  logic [9:0]           yaw_max_r;
  logic [9:0]           duty_cap_r;
  logic [TIME_BITS-1:0] cmd_timeout_r;
  logic [TIME_BITS-1:0] run_limit_r;

  // Supervisor state
  logic [7:0]       stored_value_r, stored_value_nxt;
  logic             armed_r, armed_nxt;
  logic [CNT_W-1:0] since_cmd_r, since_cmd_nxt;
  logic [CNT_W-1:0] run_elapsed_r, run_elapsed_nxt;
  logic             running_r, running_nxt;

  // Input stage and result register
  logic      stg_valid_r, stg_valid_nxt;
  in_item_t  stg_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic stg_is_tick;
  logic stg_go;
  logic in_fire;

  // Evaluation signals
  logic                    fresh;
  logic [CNT_W-1:0]        elapsed_eff;
  logic                    cut;
  logic signed [11:0]      yaw;
  logic signed [11:0]      base_s;
  logic [23:0]             bucket_led;
  logic [7:0]              code_left;
  logic [7:0]              code_right;

  function automatic logic [7:0] duty_code(input logic signed [11:0] milli,
                                           input logic [9:0] cap);
    logic signed [11:0] m;
    logic [9:0]         c;
    logic [17:0]        p;
    logic [36:0]        q;
    m = milli;
    if (m > $signed({2'b00, cap})) begin
      m = $signed({2'b00, cap});
    end
    if (m < 12'sd0) begin
      m = 12'sd0;
    end
    if (m > DUTY_FULL) begin
      m = DUTY_FULL;
    end
    c = m[9:0];
    p = ({8'b0, c} << 8) - {8'b0, c};
    q = {19'b0, p} * {18'b0, RECIP_1000};
    return q[RECIP_SHIFT+7:RECIP_SHIFT];
  endfunction

  // Handshake: a tick needs room in the result register, a command does not
  assign stg_is_tick = (stg_item_r.op == OP_TICK);
  assign stg_go      = stg_valid_r && (!stg_is_tick || !out_valid_r || out_ready);
  assign in_ready    = !stg_valid_r || stg_go;
  assign in_fire     = in_valid && in_ready;
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  // Stage and result valid bits
  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_fire) begin
      stg_valid_nxt = 1'b1;
    end else if (stg_go) begin
      stg_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (stg_go && stg_is_tick) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Freshness, run start and cut-off
  assign fresh       = armed_r && (since_cmd_r < {1'b0, cmd_timeout_r});
  assign elapsed_eff = (fresh && !running_r) ? '0 : run_elapsed_r;
  assign cut         = fresh && (elapsed_eff > {1'b0, run_limit_r});

  // Pick the yaw bucket from the stored value
  assign base_s = $signed({2'b00, base_duty_r});
  always_comb begin
    case (stored_value_r) inside
      [8'd0:8'd15]: begin
        yaw        = -$signed({2'b00, yaw_max_r});
        bucket_led = LED_STRONG_LEFT;
      end
      [8'd16:8'd31]: begin
        yaw        = -$signed({3'b000, yaw_max_r[9:1]});
        bucket_led = LED_SOFT_LEFT;
      end
      [8'd32:8'd47]: begin
        yaw        = 12'sd0;
        bucket_led = LED_STRAIGHT;
      end
      [8'd48:8'd63]: begin
        yaw        = $signed({3'b000, yaw_max_r[9:1]});
        bucket_led = LED_SOFT_RIGHT;
      end
      default: begin
        yaw        = $signed({2'b00, yaw_max_r});
        bucket_led = LED_STRONG_RIGHT;
      end
    endcase
  end

  assign code_left  = duty_code(base_s + yaw, duty_cap_r);
  assign code_right = duty_code(base_s - yaw, duty_cap_r);

  // Build the result item
  always_comb begin
    out_data_nxt            = '0;
    out_data_nxt.is_running = fresh;
    out_data_nxt.is_cut_off = cut;
    if (!fresh) begin
      out_data_nxt.led_color = armed_r ? LED_STALE : LED_IDLE;
    end else if (cut) begin
      out_data_nxt.led_color = LED_CUTOFF;
    end else begin
      out_data_nxt.led_color        = bucket_led;
      out_data_nxt.duty_front_left  = code_left;
      out_data_nxt.duty_rear_left   = code_left;
      out_data_nxt.duty_front_right = code_right;
      out_data_nxt.duty_rear_right  = code_right;
    end
  end

  // Advance the state for the item leaving the stage
  always_comb begin
    stored_value_nxt = stored_value_r;
    armed_nxt        = armed_r;
    since_cmd_nxt    = since_cmd_r;
    run_elapsed_nxt  = run_elapsed_r;
    running_nxt      = running_r;
    if (stg_go) begin
      if (stg_is_tick) begin
        running_nxt     = fresh;
        since_cmd_nxt   = (&since_cmd_r) ? since_cmd_r : since_cmd_r + 1'b1;
        run_elapsed_nxt = (&elapsed_eff) ? elapsed_eff : elapsed_eff + 1'b1;
      end else if (stg_item_r.command_value <= VALUE_MAX) begin
        stored_value_nxt = stg_item_r.command_value;
        armed_nxt        = stg_item_r.arm_request;
        since_cmd_nxt    = '0;
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r    <= 1'b0;
      out_valid_r    <= 1'b0;
      stored_value_r <= '0;
      armed_r        <= 1'b0;
      since_cmd_r    <= '0;
      run_elapsed_r  <= '0;
      running_r      <= 1'b0;
    end else begin
      stg_valid_r    <= stg_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      stored_value_r <= stored_value_nxt;
      armed_r        <= armed_nxt;
      since_cmd_r    <= since_cmd_nxt;
      run_elapsed_r  <= run_elapsed_nxt;
      running_r      <= running_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_item_r <= in_data;
    end
    if (stg_go && stg_is_tick) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_duty_r   <= BASE_DUTY_RST;
      yaw_max_r     <= YAW_MAX_RST;
      duty_cap_r    <= DUTY_CAP_RST;
      cmd_timeout_r <= TIME_BITS'(CMD_TIMEOUT_RST);
      run_limit_r   <= TIME_BITS'(RUN_LIMIT_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_DUTY:   base_duty_r   <= cfg_data[9:0];
        CFG_YAW_MAX:     yaw_max_r     <= cfg_data[9:0];
        CFG_DUTY_CAP:    duty_cap_r    <= cfg_data[9:0];
        CFG_CMD_TIMEOUT: cmd_timeout_r <= TIME_BITS'(cfg_data);
        CFG_RUN_LIMIT:   run_limit_r   <= TIME_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // A cut-off result always belongs to an active run
  a_cut_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.is_cut_off |-> out_data_r.is_running)
    else $error("cut-off result without an active run");

  // Motors are held at zero unless running and not cut off
  a_duty_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (!out_data_r.is_running || out_data_r.is_cut_off) |->
      (out_data_r.duty_front_left == 8'd0) && (out_data_r.duty_front_right == 8'd0) &&
      (out_data_r.duty_rear_left == 8'd0) && (out_data_r.duty_rear_right == 8'd0))
    else $error("nonzero duty while motors are stopped");

  // Every tick leaving the stage fills the result register
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    stg_go && stg_is_tick |=> out_valid_r)
    else $error("tick evaluated without a result");

  // An empty stage always takes a new item
  a_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !stg_valid_r |-> in_ready)
    else $error("empty input stage refuses an item");

  // A command clears the freshness timer when its value is in range
  a_cmd_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stg_go && !stg_is_tick && (stg_item_r.command_value <= VALUE_MAX) |=>
      since_cmd_r == '0)
    else $error("valid command did not restart the timer");

endmodule
